[rtl/core/text_console_writer_core_macros.svh]
// Assertion macros used by the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TCW_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define TCW_ASSERT(name, prop, msg) \
  `TCW_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/tcw_pkg.sv]
// Types, codes and constants of the text console writer.
package tcw_pkg;

  localparam int DefaultRows    = 25;
  localparam int DefaultColumns = 80;

  localparam logic [15:0] BLANK_CELL   = 16'h0020;
  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  NULL_CODE    = 8'h00;

  typedef enum logic [2:0] {
    CMD_WRITE        = 3'd0,
    CMD_CURSOR       = 3'd1,
    CMD_CLEAR_ROW    = 3'd2,
    CMD_CLEAR_SCREEN = 3'd3,
    CMD_READ         = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_COPY,
    ST_DRAIN,
    ST_PUT,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic [7:0] target_row;
    logic [7:0] target_column;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } res_t;

endpackage

[rtl/core/text_console_writer_core.sv]
// Text-mode console engine: cell memory, cursor and command sequencer.
//
// Channel   Direction  Handshake                      Payload
// command   in         start high, busy low at edge   cmd_i  (tcw_pkg::cmd_t)
// result    out        done_o high for one cycle      res_o  (tcw_pkg::res_t)
//
// Every transaction returns exactly one result. Set cursor, null characters,
// unknown commands and printable writes without scroll finish straight from
// idle; a read passes through ST_READ, as the cell memory read is registered.
// Newline padding, a row clear and a screen clear run in ST_FILL, paced by the
// single memory write port filling one cell per cycle. A write that scrolls
// runs ST_COPY, ST_DRAIN, ST_FILL and ST_PUT: the copy streams one cell per
// cycle through the read and write ports, then the last row is blanked.
// After reset the memory is swept to blank cells with busy high. The receiver
// cannot stall: the result is shown in the cycle after the command completes
// and busy drops in that same cycle.
module text_console_writer_core #(
  parameter int ROWS    = tcw_pkg::DefaultRows,
  parameter int COLUMNS = tcw_pkg::DefaultColumns
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          done_o,
  output tcw_pkg::res_t res_o
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  // The column also holds COLUMNS itself, which marks a full line.
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam logic [ADDR_W-1:0] LastBase = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LastCell = ADDR_W'(CELLS - 1);

  function automatic logic [ADDR_W-1:0] addr_of(logic [ROW_W-1:0] r,
                                                 logic [COL_W-1:0] c);
    return ADDR_W'(32'(r) * COLUMNS + 32'(c));
  endfunction

  // Cell memory: one write port, one registered read port.
  logic [15:0]       mem [CELLS];
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;
  logic [15:0]       rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [15:0]       fill_q, fill_d;
  logic [15:0]       char_q, char_d;
  logic              put_q, put_d;
  logic              done_q, done_d;
  logic [15:0]       data_q, data_d;

  logic [ROW_W-1:0]  trow;
  logic [COL_W-1:0]  tcol;
  logic [COL_W-1:0]  col_clamped;
  logic [7:0]        attr;
  logic [15:0]       clear_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      addr_q  <= '0;
      put_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      addr_q  <= addr_d;
      put_q   <= put_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    fill_q <= fill_d;
    char_q <= char_d;
    data_q <= data_d;
  end

  always_comb begin
    trow = (32'(cmd_i.target_row) < ROWS) ? ROW_W'(cmd_i.target_row)
                                          : ROW_W'(ROWS - 1);
    tcol = (32'(cmd_i.target_column) < COLUMNS) ? COL_W'(cmd_i.target_column)
                                                : COL_W'(COLUMNS - 1);
    // Clears pull a full-line cursor back onto the last column.
    col_clamped = (col_q >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : col_q;
    attr        = {cmd_i.bg_color, cmd_i.fg_color};
    clear_cell  = {cmd_i.fg_color, cmd_i.fg_color, SPACE_CODE};

    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    addr_d  = addr_q;
    last_d  = last_q;
    fill_d  = fill_q;
    char_d  = char_q;
    put_d   = put_q;
    done_d  = 1'b0;
    data_d  = 16'h0000;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = fill_q;
    raddr   = addr_q;

    case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        wdata = BLANK_CELL;
        if (addr_q == LastCell) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd_e'(cmd_i.command))
            CMD_WRITE: begin
              if (cmd_i.char_code == NULL_CODE) begin
                done_d = 1'b1;
              end else if (cmd_i.char_code == NEWLINE_CODE) begin
                if (col_q >= COL_W'(COLUMNS)) begin
                  done_d = 1'b1;
                end else begin
                  addr_d  = addr_of(row_q, col_q);
                  last_d  = addr_of(row_q, COL_W'(COLUMNS - 1));
                  fill_d  = {attr, SPACE_CODE};
                  col_d   = COL_W'(COLUMNS);
                  put_d   = 1'b0;
                  state_d = ST_FILL;
                end
              end else if (col_q >= COL_W'(COLUMNS) &&
                           row_q == ROW_W'(ROWS - 1)) begin
                // Wrap past the last row: scroll, blank, then store.
                addr_d  = '0;
                last_d  = LastBase - ADDR_W'(1);
                char_d  = {attr, cmd_i.char_code};
                col_d   = COL_W'(1);
                put_d   = 1'b1;
                state_d = ST_COPY;
              end else begin
                we     = 1'b1;
                wdata  = {attr, cmd_i.char_code};
                done_d = 1'b1;
                if (col_q >= COL_W'(COLUMNS)) begin
                  waddr = addr_of(row_q + ROW_W'(1), '0);
                  row_d = row_q + ROW_W'(1);
                  col_d = COL_W'(1);
                end else begin
                  waddr = addr_of(row_q, col_q);
                  col_d = col_q + COL_W'(1);
                end
              end
            end
            CMD_CURSOR: begin
              row_d  = trow;
              col_d  = tcol;
              done_d = 1'b1;
            end
            CMD_CLEAR_ROW: begin
              addr_d  = addr_of(trow, '0);
              last_d  = addr_of(trow, COL_W'(COLUMNS - 1));
              fill_d  = clear_cell;
              col_d   = col_clamped;
              put_d   = 1'b0;
              state_d = ST_FILL;
            end
            CMD_CLEAR_SCREEN: begin
              addr_d  = '0;
              last_d  = LastCell;
              fill_d  = clear_cell;
              col_d   = col_clamped;
              put_d   = 1'b0;
              state_d = ST_FILL;
            end
            CMD_READ: begin
              raddr   = addr_of(trow, tcol);
              state_d = ST_READ;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        wdata = fill_q;
        if (addr_q == last_q) begin
          if (put_q) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_COPY: begin
        // Read one row ahead while the previous cell lands one row up.
        // Writes always trail reads, so no source is overwritten early.
        raddr = ADDR_W'(32'(addr_q) + COLUMNS);
        we    = (addr_q != '0);
        waddr = addr_q - ADDR_W'(1);
        wdata = rdata_q;
        if (addr_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        we      = 1'b1;
        waddr   = addr_q;
        wdata   = rdata_q;
        addr_d  = LastBase;
        last_d  = LastCell;
        fill_d  = BLANK_CELL;
        state_d = ST_FILL;
      end
      ST_PUT: begin
        we      = 1'b1;
        waddr   = LastBase;
        wdata   = char_q;
        put_d   = 1'b0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        data_d  = rdata_q;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy                = (state_q != ST_IDLE);
  assign done_o              = done_q;
  assign res_o.cell_data     = data_q;
  assign res_o.cursor_row    = 5'(row_q);
  assign res_o.cursor_column = 7'(col_q);

endmodule

[rtl/core/tcw_checker.sv]
// Port-level assertions for the text console writer, bound to the console writer core.
`include "text_console_writer_core_macros.svh"

module tcw_checker #(
  parameter int ROWS    = tcw_pkg::DefaultRows,
  parameter int COLUMNS = tcw_pkg::DefaultColumns
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input tcw_pkg::cmd_t cmd_i,
  input logic          done_o,
  input tcw_pkg::res_t res_o
);
  import tcw_pkg::*;

  logic accepted;
  logic cursor_set;

  assign accepted   = start && !busy;
  assign cursor_set = accepted && (cmd_i.command == CMD_CURSOR);

  // An accepted transaction either keeps the block busy or completes at once.
  `TCW_ASSERT(a_accept_progress, accepted |=> (busy || done_o), "accept without progress")

  // A result only follows an accepted transaction or work in flight.
  `TCW_ASSERT(a_done_has_cause, done_o |-> $past(busy || start), "result without transaction")

  // Setting the cursor completes in the next cycle.
  `TCW_ASSERT(a_cursor_single, cursor_set |=> done_o, "slow cursor set")

  // The reported column never passes the full-line mark.
  `TCW_ASSERT(a_column_range, done_o |-> (32'(res_o.cursor_column) <= COLUMNS), "column too large")

  // The reported row always lies on the screen.
  `TCW_ASSERT(a_row_range, done_o |-> (32'(res_o.cursor_row) < ROWS), "row out of range")

endmodule

bind text_console_writer_core tcw_checker #(
  .ROWS    (ROWS),
  .COLUMNS (COLUMNS)
) u_tcw_checker (.*);
